>>> hw/rtl/signed_int_to_decimal_ascii_unit_macros.svh
// Assertion macros used by the checker file of the decimal text unit.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SITDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sitda assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SITDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sitda assertion failed");

`endif

>>> hw/rtl/sitda_pkg.sv
// Shared types and constants of the decimal text unit.
// Depends on nothing; used by the digit cell and the top level.
package sitda_pkg;

    localparam int unsigned DIGIT_BITS = 4;
    localparam int unsigned CHAR_BITS  = 8;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'd45;

    // Control group that steers every cell of the digit row.
    typedef struct packed {
        logic clear;
        logic bit_shift;
        logic digit_shift;
    } t_cell_ctrl;

endpackage

>>> hw/rtl/sitda_if.sv
// Valid/ready channel interfaces: signed value in, text character out.
// Depends on sitda_pkg for the character width.
interface sitda_value_if #(
    parameter int unsigned VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_char_if;
    logic                             valid;
    logic                             ready;
    logic [sitda_pkg::CHAR_BITS-1:0]  character;
    logic                             last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

>>> hw/rtl/sitda_cell.sv
// One BCD digit cell of the shift-and-add-3 row.
// Depends on sitda_pkg for the control struct and digit width.
module sitda_cell (
    input  logic                                i_clk,
    input  sitda_pkg::t_cell_ctrl               i_ctrl,
    input  logic                                i_bit,
    input  logic [sitda_pkg::DIGIT_BITS-1:0]    i_digit,
    output logic                                o_carry,
    output logic [sitda_pkg::DIGIT_BITS-1:0]    o_digit
);

    logic [sitda_pkg::DIGIT_BITS-1:0] r_digit;
    logic [sitda_pkg::DIGIT_BITS-1:0] w_adj;

    // Correct a digit of five or more so the next doubling carries out.
    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_adj[sitda_pkg::DIGIT_BITS-1];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_digit <= '0;
        end else if (i_ctrl.bit_shift) begin
            r_digit <= {w_adj[sitda_pkg::DIGIT_BITS-2:0], i_bit};
        end else if (i_ctrl.digit_shift) begin
            r_digit <= i_digit;
        end
    end

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii_unit.sv
// Channel     | Dir | Payload                 | Transfer when
// i_in        | in  | value [VALUE_BITS] s    | valid & ready
// o_out       | out | character [8], last     | valid & ready
// One item: taken in the idle state, shifted bit by bit through the digit row, then a
// minus sign for a negative value, then each leading zero dropped, the skip left and
// one character sent per digit.
// Synchronous active-low reset clears the sequencer and the output valid.
// A stalled output holds its character and holds back the sign and digit steps; a new
// value is taken once the last character sits in the output register.
module signed_int_to_decimal_ascii_unit #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sitda_value_if.sink          i_in,
    sitda_char_if.source         o_out
);

    // Enough decimal digits for a magnitude of 2^(VALUE_BITS-1).
    localparam int unsigned DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int unsigned CNT_W  = $clog2(DIGITS + 1);
    localparam int unsigned BIT_W  = $clog2(VALUE_BITS);
    localparam int unsigned DW     = sitda_pkg::DIGIT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } t_state;

    t_state                         r_state;
    logic [VALUE_BITS-1:0]          r_mag;
    logic                           r_neg;
    logic [BIT_W-1:0]               r_bit;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_out_valid;
    logic [sitda_pkg::CHAR_BITS-1:0] r_out_char;
    logic                           r_out_last;

    sitda_pkg::t_cell_ctrl          w_ctrl;
    logic                           w_accept;
    logic                           w_slot;
    logic                           w_load;
    logic                           w_top_zero;
    logic [DW-1:0]                  w_top;
    logic [VALUE_BITS-1:0]          w_in_mag;
    logic                           w_carry [DIGITS];
    logic [DW-1:0]                  w_digit [DIGITS];

    assign i_in.ready      = (r_state == ST_IDLE);
    assign w_accept        = i_in.valid && i_in.ready;
    assign w_slot          = !r_out_valid || o_out.ready;
    assign w_load          = w_slot && ((r_state == ST_SIGN) || (r_state == ST_EMIT));
    assign w_top           = w_digit[DIGITS-1];
    assign w_top_zero      = (w_top == '0);
    assign w_in_mag        = i_in.value[VALUE_BITS-1] ? (~i_in.value + VALUE_BITS'(1))
                                                      : i_in.value;

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;

    // Digit row: least significant cell takes the magnitude bit stream.
    for (genvar k = 0; k < DIGITS; k++) begin : g_cell
        logic          w_bit_in;
        logic [DW-1:0] w_digit_in;
        if (k == 0) begin : g_first
            assign w_bit_in   = r_mag[VALUE_BITS-1];
            assign w_digit_in = '0;
        end else begin : g_next
            assign w_bit_in   = w_carry[k-1];
            assign w_digit_in = w_digit[k-1];
        end
        sitda_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_bit   (w_bit_in),
            .i_digit (w_digit_in),
            .o_carry (w_carry[k]),
            .o_digit (w_digit[k])
        );
    end

    always_comb begin
        w_ctrl             = '0;
        w_ctrl.clear       = w_accept;
        w_ctrl.bit_shift   = (r_state == ST_CONV);
        w_ctrl.digit_shift = ((r_state == ST_SKIP) && w_top_zero && (r_cnt > CNT_W'(1)))
                           || ((r_state == ST_EMIT) && w_slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the output once it transfers, unless a new character loads.
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_mag   <= w_in_mag;
                        r_neg   <= i_in.value[VALUE_BITS-1];
                        r_bit   <= BIT_W'(VALUE_BITS - 1);
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_mag <= r_mag << 1;
                    r_bit <= r_bit - BIT_W'(1);
                    if (r_bit == '0) begin
                        r_cnt   <= CNT_W'(DIGITS);
                        r_state <= r_neg ? ST_SIGN : ST_SKIP;
                    end
                end
                ST_SIGN: begin
                    if (w_slot) begin
                        r_out_char  <= sitda_pkg::ASCII_MINUS;
                        r_out_last  <= 1'b0;
                        r_state     <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    if (w_top_zero && (r_cnt > CNT_W'(1))) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_slot) begin
                        r_out_char  <= sitda_pkg::ASCII_ZERO
                                     + {{(sitda_pkg::CHAR_BITS - DW){1'b0}}, w_top};
                        r_out_last  <= (r_cnt == CNT_W'(1));
                        r_cnt       <= r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/sitda_checker.sv
// Port-level checks of the decimal text unit, bound to the top level.
// Depends on signed_int_to_decimal_ascii_unit_macros.svh and sitda_pkg.
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sitda_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    // A stalled character holds until it transfers.
    `SITDA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_char) && $stable(i_out_last))

    // Only a minus sign or a decimal digit leaves the block.
    `SITDA_ASSERT_SAME(a_char_set, i_clk, i_rst_n, i_out_valid,
        (i_out_char == sitda_pkg::ASCII_MINUS) || ((i_out_char >= sitda_pkg::ASCII_ZERO)
        && (i_out_char <= sitda_pkg::ASCII_ZERO + 8'd9)))

    // A minus sign always has digits after it.
    `SITDA_ASSERT_SAME(a_minus_not_last, i_clk, i_rst_n,
        i_out_valid && (i_out_char == sitda_pkg::ASCII_MINUS), !i_out_last)

    // One value at a time: ready drops right after a transfer in.
    `SITDA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.character),
    .i_out_last  (o_out.last)
);

>>> sim/tb.sv
// Self-checking bench for signed_int_to_decimal_ascii_unit: random and corner integers in,
// every text character predicted here and compared in order. Depends on sitda_pkg, the
// channel interfaces in sitda_if.sv and the unit itself.
module tb;

    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [sitda_pkg::CHAR_BITS-1:0] code;
        logic                            last;
    } t_text_char;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sitda_value_if #(.VALUE_BITS(VALUE_BITS)) in_if ();
    sitda_char_if out_if ();

    signed_int_to_decimal_ascii_unit #(.VALUE_BITS(VALUE_BITS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic signed [VALUE_BITS-1:0] value_q[$];
    t_text_char                   text_q[$];
    int unsigned in_taken = 0;
    int unsigned offered_n = 0;
    int unsigned chars_seen = 0;
    int unsigned faults = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hush_a = 0;
    int unsigned hush_b = 0;
    bit          long_hold_done = 1'b0;

    // Mostly back to back, sometimes a short gap, now and then a long gap.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Queue the decimal text of one accepted value.
    function automatic void push_decimal_text(logic [VALUE_BITS-1:0] raw);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digs[12];
        int                    nd;
        t_text_char            ch;
        nd = 0;
        mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
        do begin
            digs[nd] = 4'(mag % 10);
            mag = mag / 10;
            nd++;
        end while (mag != 0);
        if (raw[VALUE_BITS-1]) begin
            ch.code = sitda_pkg::ASCII_MINUS;
            ch.last = 1'b0;
            text_q.push_back(ch);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            ch.code = sitda_pkg::ASCII_ZERO + sitda_pkg::CHAR_BITS'(digs[i]);
            ch.last = (i == 0);
            text_q.push_back(ch);
        end
    endfunction

    task automatic flag_fault(string what, t_text_char want, t_text_char got);
        faults++;
        if (faults <= 10)
            $display("tb: %s at char %0d: expected code %0d last %0b, got code %0d last %0b",
                     what, chars_seen, want.code, want.last, got.code, got.last);
    endtask

    // Sender: offer the next value once the current one has transferred.
    always @(negedge i_clk) begin
        if (i_rst_n && !(in_if.valid && in_taken != offered_n)) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                in_if.valid <= 1'b0;
            end else if (value_q.size() != 0 &&
                         !((offered_n == hush_a || offered_n == hush_b) && text_q.size() != 0)) begin
                in_if.value <= value_q.pop_front();
                in_if.valid <= 1'b1;
                offered_n <= offered_n + 1;
                send_gap <= ((offered_n / 40) % 4 == 2) ? 0 : pick_gap();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold while the sender keeps offering.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (recv_stall != 0) begin
                recv_stall <= recv_stall - 1;
                out_if.ready <= 1'b0;
            end else if (!long_hold_done && chars_seen >= 200) begin
                long_hold_done <= 1'b1;
                recv_stall <= LONG_HOLD;
                out_if.ready <= 1'b0;
            end else if ((chars_seen / 64) % 4 != 1 && $urandom_range(99, 0) < 25) begin
                recv_stall <= pick_gap();
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Predict on input transfers, check on output transfers.
    always @(posedge i_clk) begin
        t_text_char got;
        t_text_char want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                push_decimal_text(in_if.value);
                in_taken <= in_taken + 1;
            end
            if (out_if.valid && out_if.ready) begin
                got.code = out_if.character;
                got.last = out_if.last;
                if (text_q.size() == 0) begin
                    want = '0;
                    flag_fault("unexpected character", want, got);
                end else begin
                    want = text_q.pop_front();
                    if (got.code !== want.code || got.last !== want.last)
                        flag_fault("mismatch", want, got);
                end
                chars_seen <= chars_seen + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        int unsigned       pick;
        int unsigned       ndig;
        longint unsigned   lo;
        longint unsigned   hi;
        logic [VALUE_BITS-1:0] v;
        int unsigned       total;

        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.value = '0;
        out_if.ready = 1'b0;

        // Corners: zero, single digits, digit-count boundaries, both extremes.
        value_q = '{0, 1, -1, 5, -7, 9, -9, 10, -10, 99, 100, -101, 12345,
                    999999999, 1000000000, -1000000000, 2147483647, -2147483647,
                    32'sh8000_0000, 1234567890, -1234567890};
        hush_a = value_q.size();

        repeat (200) begin
            pick = $urandom_range(3, 0);
            case (pick)
                0: v = $urandom;
                1: begin
                    v = $urandom_range(20, 0);
                    if ($urandom_range(1, 0))
                        v = -v;
                end
                2: begin
                    ndig = $urandom_range(10, 1);
                    lo = 1;
                    repeat (ndig - 1) lo = lo * 10;
                    hi = lo * 10 - 1;
                    if (hi > 64'd2147483647)
                        hi = 64'd2147483647;
                    v = $urandom_range(32'(hi), 32'(lo));
                    if ($urandom_range(1, 0))
                        v = -v;
                end
                default: begin
                    v = 32'h8000_0000 + $urandom_range(15, 0);
                    if ($urandom_range(1, 0))
                        v = ~v;
                end
            endcase
            value_q.push_back(v);
        end
        hush_b = hush_a + 110;
        total = value_q.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (in_taken == total);
        wait (text_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (faults == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

>>> signed_int_to_decimal_ascii_unit.f
+incdir+hw/rtl
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_if.sv
hw/rtl/sitda_cell.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
hw/rtl/sitda_checker.sv
sim/tb.sv
